// ===== design/max_pool_2d_plane_defines.svh =====
// assertion macros for the max pooling block
// expects signals named clock and reset in the module that uses them
`ifndef MAX_POOL_2D_PLANE_DEFINES_SVH
`define MAX_POOL_2D_PLANE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MP2D_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("max_pool_2d_plane: same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define MP2D_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("max_pool_2d_plane: next-cycle check failed");

`endif

// ===== design/mp2d_pkg.sv =====
// shared types, constants and helpers for the max pooling block
// no dependencies
package mp2d_pkg;

   // sizes of the plane store and sample format
   localparam int MAX_HEIGHT  = 64;
   localparam int MAX_WIDTH   = 64;
   localparam int MAX_KERNEL  = 8;
   localparam int MAX_STRIDE  = 8;
   localparam int SAMPLE_BITS = 16;

   // register and datapath widths
   localparam int KDIM_W      = 4;
   localparam int PAD_W       = 3;
   localparam int DIM_W       = 7;
   localparam int OUT_W       = 6;
   localparam int GEO_W       = 11;
   localparam int LIN_W       = 2 * DIM_W;
   localparam int KCNT_W      = $clog2(MAX_KERNEL);
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_HEIGHT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_WIDTH  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_ROWS   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_COLS   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_ROWS      = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_COLS      = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_HEIGHT  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_WIDTH   = 4'd7;

   // opcodes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PRODUCE = 1'b1;

   // most negative sample, stands for an empty window
   localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // request beat
   typedef struct packed {
      logic                          opcode;
      logic signed [SAMPLE_BITS-1:0] sample;
   } mp2d_req_type;

   // result beat
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pooled;
      logic                          last_of_plane;
   } mp2d_rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_FLUSH
   } mp2d_state_type;

   // force a kernel or stride setting into 1..hi
   function automatic logic [KDIM_W-1:0] clamp_step(input logic [KDIM_W-1:0] value,
                                                    input int hi);
      logic [KDIM_W-1:0] result;
      if (value == '0) begin
         result = KDIM_W'(1);
      end else if (int'(value) > hi) begin
         result = KDIM_W'(hi);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ===== design/max_pool_2d_plane.sv =====
// max_pool_2d_plane: 2d max pooling over one plane held in an on-chip sample store
// depends on mp2d_pkg and max_pool_2d_plane_defines.svh
// load beat: busy stays low, so loads may arrive every cycle
// produce beat: busy through setup, one store read per window cell, and flush;
// result strobe in the first cycle with busy low; one compare unit walks the window,
// so a new produce is taken only once busy drops
// synchronous reset clears config to 2,2,2,2,0,0,64,64 and the load and output counters; store undefined
`include "max_pool_2d_plane_defines.svh"

module max_pool_2d_plane #(
   parameter int MAX_HEIGHT = mp2d_pkg::MAX_HEIGHT,
   parameter int MAX_WIDTH  = mp2d_pkg::MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mp2d_pkg::mp2d_req_type              req_data,
   output logic                                rsp_valid,
   output mp2d_pkg::mp2d_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mp2d_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mp2d_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mp2d_pkg::*;

   localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = (ADDR_W + 1 > LIN_W) ? ADDR_W + 1 : LIN_W;

   // config registers
   logic [KDIM_W-1:0] kh_cfg_ff, kw_cfg_ff, sr_cfg_ff, sc_cfg_ff;
   logic [PAD_W-1:0]  pr_cfg_ff, pc_cfg_ff;
   logic [DIM_W-1:0]  ph_cfg_ff, pw_cfg_ff;

   // effective settings
   logic [KDIM_W-1:0] kh, kw, sr, sc;
   logic [DIM_W-1:0]  ph, pw;

   // sequencer
   mp2d_state_type state_ff, state_in;
   logic           setup_active, scan_active, flush_active;
   logic           accept, load_accept, produce_accept, csr_write;

   // position counters
   logic [ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic [LIN_W-1:0]  plane_count;
   logic [POS_W-1:0]  pos_inc;
   logic [OUT_W-1:0]  out_row_ff, out_row_in, out_col_ff, out_col_in;

   // window walk
   logic [KCNT_W-1:0]       k1_ff, k1_in, k2_ff, k2_in;
   logic                    col_last, row_last, last_cell;
   logic signed [GEO_W-1:0] top_ff, left_ff, top_in, left_in;
   logic signed [GEO_W-1:0] row_pos, col_pos;
   logic                    row_ok, col_ok;
   logic [LIN_W-1:0]        lin;
   logic [ADDR_W-1:0]       rd_addr;
   logic [GEO_W-1:0]        row_need, row_span, col_need, col_span;
   logic                    row_wrap_ff, col_wrap_ff, row_wrap_in, col_wrap_in;

   // store and compare unit
   logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_valid_ff, rd_valid_in;
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in, best_now;

   // result register
   logic         rsp_valid_ff;
   mp2d_rsp_type rsp_data_ff;

   // effective settings from the raw registers
   always_comb begin
      kh = clamp_step(kh_cfg_ff, MAX_KERNEL);
      kw = clamp_step(kw_cfg_ff, MAX_KERNEL);
      sr = clamp_step(sr_cfg_ff, MAX_STRIDE);
      sc = clamp_step(sc_cfg_ff, MAX_STRIDE);
      ph = (ph_cfg_ff == '0) ? DIM_W'(1) :
           ((int'(ph_cfg_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : ph_cfg_ff);
      pw = (pw_cfg_ff == '0) ? DIM_W'(1) :
           ((int'(pw_cfg_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : pw_cfg_ff);
   end

   // handshakes
   assign accept         = start && !busy;
   assign load_accept    = accept && (req_data.opcode == OP_LOAD);
   assign produce_accept = accept && (req_data.opcode == OP_PRODUCE);
   assign csr_write      = csr_valid && csr_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (produce_accept) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_cell) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state decode
   always_comb begin
      busy         = 1'b1;
      csr_ready    = 1'b0;
      setup_active = 1'b0;
      scan_active  = 1'b0;
      flush_active = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            csr_ready = 1'b1;
         end
         ST_SETUP: begin
            setup_active = 1'b1;
         end
         ST_SCAN: begin
            scan_active = 1'b1;
         end
         ST_FLUSH: begin
            flush_active = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // load position with wrap at the end of the plane
   always_comb begin
      plane_count = LIN_W'(ph) * LIN_W'(pw);
      pos_inc     = POS_W'(load_pos_ff) + POS_W'(1);
      load_pos_in = (pos_inc >= POS_W'(plane_count)) ? '0 : ADDR_W'(pos_inc);
   end

   // window origin and end-of-row / end-of-plane tests for the current output
   always_comb begin
      top_in      = $signed(GEO_W'(out_row_ff) * GEO_W'(sr)) - $signed(GEO_W'(pr_cfg_ff));
      left_in     = $signed(GEO_W'(out_col_ff) * GEO_W'(sc)) - $signed(GEO_W'(pc_cfg_ff));
      row_need    = (GEO_W'(out_row_ff) + GEO_W'(1)) * GEO_W'(sr) + GEO_W'(kh);
      row_span    = GEO_W'(ph) + GEO_W'({pr_cfg_ff, 1'b0});
      col_need    = (GEO_W'(out_col_ff) + GEO_W'(1)) * GEO_W'(sc) + GEO_W'(kw);
      col_span    = GEO_W'(pw) + GEO_W'({pc_cfg_ff, 1'b0});
      row_wrap_in = (&out_row_ff) || (row_need > row_span);
      col_wrap_in = (&out_col_ff) || (col_need > col_span);
   end

   // current window cell, bounds test and store address
   always_comb begin
      row_pos     = top_ff + $signed(GEO_W'(k1_ff));
      col_pos     = left_ff + $signed(GEO_W'(k2_ff));
      row_ok      = !row_pos[GEO_W-1] && (row_pos < $signed(GEO_W'(ph)));
      col_ok      = !col_pos[GEO_W-1] && (col_pos < $signed(GEO_W'(pw)));
      lin         = LIN_W'(row_pos[DIM_W-1:0]) * LIN_W'(pw) + LIN_W'(col_pos[DIM_W-1:0]);
      rd_addr     = ADDR_W'(lin);
      rd_valid_in = scan_active && row_ok && col_ok;
   end

   // window cell counters
   always_comb begin
      col_last  = (KDIM_W'(k2_ff) == kw - KDIM_W'(1));
      row_last  = (KDIM_W'(k1_ff) == kh - KDIM_W'(1));
      last_cell = row_last && col_last;
      k1_in     = k1_ff;
      k2_in     = k2_ff;
      if (setup_active) begin
         k1_in = '0;
         k2_in = '0;
      end else if (scan_active) begin
         if (col_last) begin
            k2_in = '0;
            k1_in = k1_ff + KCNT_W'(1);
         end else begin
            k2_in = k2_ff + KCNT_W'(1);
         end
      end
   end

   // shared compare unit
   always_comb begin
      best_now = (rd_valid_ff && (rd_data_ff > best_ff)) ? rd_data_ff : best_ff;
      best_in  = setup_active ? MIN_SAMPLE : best_now;
   end

   // output counters advance once per produced result
   always_comb begin
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (flush_active) begin
         if (col_wrap_ff) begin
            out_col_in = '0;
            out_row_in = row_wrap_ff ? '0 : out_row_ff + OUT_W'(1);
         end else begin
            out_col_in = out_col_ff + OUT_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_pos_ff  <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kh_cfg_ff    <= KDIM_W'(2);
         kw_cfg_ff    <= KDIM_W'(2);
         sr_cfg_ff    <= KDIM_W'(2);
         sc_cfg_ff    <= KDIM_W'(2);
         pr_cfg_ff    <= '0;
         pc_cfg_ff    <= '0;
         ph_cfg_ff    <= DIM_W'(64);
         pw_cfg_ff    <= DIM_W'(64);
      end else begin
         state_ff     <= state_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= flush_active;
         if (load_accept) load_pos_ff <= load_pos_in;
         // config beat
         if (csr_write) begin
            unique case (csr_index)
               CSR_KERNEL_HEIGHT: kh_cfg_ff <= csr_data[KDIM_W-1:0];
               CSR_KERNEL_WIDTH:  kw_cfg_ff <= csr_data[KDIM_W-1:0];
               CSR_STRIDE_ROWS:   sr_cfg_ff <= csr_data[KDIM_W-1:0];
               CSR_STRIDE_COLS:   sc_cfg_ff <= csr_data[KDIM_W-1:0];
               CSR_PAD_ROWS:      pr_cfg_ff <= csr_data[PAD_W-1:0];
               CSR_PAD_COLS:      pc_cfg_ff <= csr_data[PAD_W-1:0];
               CSR_PLANE_HEIGHT:  ph_cfg_ff <= csr_data[DIM_W-1:0];
               CSR_PLANE_WIDTH:   pw_cfg_ff <= csr_data[DIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k1_ff   <= k1_in;
      k2_ff   <= k2_in;
      best_ff <= best_in;
      if (setup_active) begin
         top_ff      <= top_in;
         left_ff     <= left_in;
         row_wrap_ff <= row_wrap_in;
         col_wrap_ff <= col_wrap_in;
      end
      if (flush_active) begin
         rsp_data_ff.pooled        <= best_now;
         rsp_data_ff.last_of_plane <= col_wrap_ff && row_wrap_ff;
      end
   end

   // plane store write port
   always_ff @(posedge clock) begin
      if (load_accept) store_mem[load_pos_ff] <= req_data.sample;
   end

   // plane store read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `MP2D_ASSERT_IMPLY(a_rsp_only_idle, rsp_valid, state_ff == ST_IDLE)
   `MP2D_ASSERT_NEXT(a_flush_gives_rsp, state_ff == ST_FLUSH, rsp_valid)
   `MP2D_ASSERT_NEXT(a_produce_starts, produce_accept, state_ff == ST_SETUP)
   `MP2D_ASSERT_IMPLY(a_scan_in_window, scan_active, KDIM_W'(k1_ff) < kh && KDIM_W'(k2_ff) < kw)

endmodule

// ===== tb/tb_max_pool_2d_plane.sv =====
// self-checking bench for max_pool_2d_plane: load and produce beats go in through
// start/busy, every pooled result is predicted in-bench and checked on the strobe
// depends on mp2d_pkg and the max_pool_2d_plane rtl
module tb_max_pool_2d_plane;
   timeunit 1ns;
   timeprecision 1ps;

   import mp2d_pkg::*;

   localparam int STORE_DEPTH   = MAX_HEIGHT * MAX_WIDTH;
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_ITEMS  = 650;

   // one queued request beat, or a marker that holds the sender until results drain
   typedef struct {
      mp2d_req_type beat;
      bit           drain;
   } pending_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   mp2d_req_type           req_data  = '0;
   logic                   rsp_valid;
   mp2d_rsp_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   max_pool_2d_plane uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   pending_type                   pending_beats[$];
   mp2d_rsp_type                  pooled_expected[$];
   logic [CSR_DATA_W-1:0]         csr_shadow [1 << CSR_INDEX_W];
   logic signed [SAMPLE_BITS-1:0] plane_copy [STORE_DEPTH];
   int                            write_ptr = 0;
   int                            win_row   = 0;
   int                            win_col   = 0;
   bit                            plan_written [STORE_DEPTH];
   int                            plan_ptr  = 0;
   int                            gap_pct   = 30;
   int                            mismatch_count = 0;
   int                            item_total = 0;

   function automatic int clip(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // register value after the block's range limits
   function automatic int setting(input logic [CSR_INDEX_W-1:0] idx);
      int v;
      v = int'(csr_shadow[idx]);
      case (idx) inside
         CSR_PAD_ROWS, CSR_PAD_COLS:           return v;
         CSR_STRIDE_ROWS, CSR_STRIDE_COLS:     return clip(v, 1, MAX_STRIDE);
         CSR_PLANE_HEIGHT:                     return clip(v, 1, MAX_HEIGHT);
         CSR_PLANE_WIDTH:                      return clip(v, 1, MAX_WIDTH);
         default:                              return clip(v, 1, MAX_KERNEL);
      endcase
   endfunction

   // bits a register keeps
   function automatic logic [CSR_DATA_W-1:0] reg_mask(input logic [CSR_INDEX_W-1:0] idx);
      case (idx) inside
         CSR_PAD_ROWS, CSR_PAD_COLS:         return CSR_DATA_W'((1 << PAD_W) - 1);
         CSR_PLANE_HEIGHT, CSR_PLANE_WIDTH:  return CSR_DATA_W'((1 << DIM_W) - 1);
         default:                            return CSR_DATA_W'((1 << KDIM_W) - 1);
      endcase
   endfunction

   // pooled outputs along one dimension, held to the counter range
   function automatic int pooled_extent(input int size, input int pad, input int k,
                                        input int step);
      int span;
      span = size + 2 * pad;
      if (span < k) return 1;
      return clip((span - k) / step + 1, 1, 1 << OUT_W);
   endfunction

   // bench copy of the block: applies one taken beat, returns 1 when it yields a result
   function automatic bit pool_beat(input mp2d_req_type beat, output mp2d_rsp_type result);
      int kh, kw, sr, sc, pr, pc, ph, pw, rows_out, cols_out, top, left, x, y;
      logic signed [SAMPLE_BITS-1:0] peak;
      result = '0;
      ph = setting(CSR_PLANE_HEIGHT);
      pw = setting(CSR_PLANE_WIDTH);
      if (beat.opcode == OP_LOAD) begin
         if (write_ptr < STORE_DEPTH) plane_copy[write_ptr] = beat.sample;
         write_ptr++;
         if (write_ptr >= ph * pw) write_ptr = 0;
         return 1'b0;
      end
      kh = setting(CSR_KERNEL_HEIGHT);
      kw = setting(CSR_KERNEL_WIDTH);
      sr = setting(CSR_STRIDE_ROWS);
      sc = setting(CSR_STRIDE_COLS);
      pr = setting(CSR_PAD_ROWS);
      pc = setting(CSR_PAD_COLS);
      rows_out = pooled_extent(ph, pr, kh, sr);
      cols_out = pooled_extent(pw, pc, kw, sc);
      top  = win_row * sr - pr;
      left = win_col * sc - pc;
      // window maximum, cells in the padding skipped
      peak = MIN_SAMPLE;
      for (int r = 0; r < kh; r++) begin
         x = top + r;
         if (x >= 0 && x < ph) begin
            for (int c = 0; c < kw; c++) begin
               y = left + c;
               if (y >= 0 && y < pw && plane_copy[x * pw + y] > peak)
                  peak = plane_copy[x * pw + y];
            end
         end
      end
      result.pooled = peak;
      // raster step; counters past the output size wrap as at the last position
      if (win_col + 1 >= cols_out) begin
         win_col = 0;
         if (win_row + 1 >= rows_out) begin
            win_row = 0;
            result.last_of_plane = 1'b1;
         end else begin
            win_row++;
         end
      end else begin
         win_col++;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // queue a beat; loads also advance the planned load pointer
   task automatic queue_beat(input logic op, input logic signed [SAMPLE_BITS-1:0] value,
                             input bit drain);
      pending_type item;
      item.beat.opcode = op;
      item.beat.sample = value;
      item.drain       = drain;
      pending_beats.push_back(item);
      if (!drain) begin
         item_total++;
         if (op == OP_LOAD) begin
            if (plan_ptr < STORE_DEPTH) plan_written[plan_ptr] = 1'b1;
            plan_ptr++;
            if (plan_ptr >= setting(CSR_PLANE_HEIGHT) * setting(CSR_PLANE_WIDTH)) plan_ptr = 0;
         end
      end
   endtask

   function automatic bit plane_written();
      int area;
      area = setting(CSR_PLANE_HEIGHT) * setting(CSR_PLANE_WIDTH);
      for (int i = 0; i < area; i++) if (!plan_written[i]) return 1'b0;
      return 1'b1;
   endfunction

   // load a whole plane from wherever the load pointer stands
   task automatic reload_plane();
      int area, count;
      area  = setting(CSR_PLANE_HEIGHT) * setting(CSR_PLANE_WIDTH);
      count = area + ((plan_ptr >= area) ? 1 : 0);
      for (int i = 0; i < count; i++) queue_beat(OP_LOAD, SAMPLE_BITS'($urandom), 1'b0);
   endtask

   // produce beats with loads and drain holds mixed in
   task automatic run_outputs(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) queue_beat(OP_LOAD, SAMPLE_BITS'($urandom), 1'b0);
         if ($urandom_range(19) == 0) queue_beat(OP_LOAD, '0, 1'b1);
         queue_beat(OP_PRODUCE, SAMPLE_BITS'($urandom), 1'b0);
      end
   endtask

   // one register write beat on the csr channel
   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      if (gap_pct != 0) repeat ($urandom_range(2)) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_PLANE_WIDTH) csr_shadow[idx] = value & reg_mask(idx);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait until the block is idle with nothing outstanding
   task automatic settle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || start || busy || rsp_valid ||
             pooled_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random window registers and a plane that stays small in area
   task automatic random_setup();
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  value, long_edge, narrow_edge;
      for (int i = CSR_KERNEL_HEIGHT; i <= CSR_PAD_COLS; i++) begin
         idx = CSR_INDEX_W'(i);
         if ($urandom_range(1) == 1) begin
            if ($urandom_range(9) == 0) value = CSR_DATA_W'($urandom);
            else if (idx == CSR_PAD_ROWS || idx == CSR_PAD_COLS)
               value = CSR_DATA_W'($urandom_range(7));
            else value = CSR_DATA_W'($urandom_range(1, 8));
            set_reg(idx, value);
         end
      end
      if ($urandom_range(7) == 0) begin
         // one long edge, the other kept narrow
         long_edge   = CSR_DATA_W'($urandom_range(9, 127));
         narrow_edge = CSR_DATA_W'($urandom_range(2));
         if ($urandom_range(1) == 1) begin
            set_reg(CSR_PLANE_HEIGHT, long_edge);
            set_reg(CSR_PLANE_WIDTH, narrow_edge);
         end else begin
            set_reg(CSR_PLANE_HEIGHT, narrow_edge);
            set_reg(CSR_PLANE_WIDTH, long_edge);
         end
      end else begin
         set_reg(CSR_PLANE_HEIGHT, CSR_DATA_W'($urandom_range(8)));
         set_reg(CSR_PLANE_WIDTH, CSR_DATA_W'($urandom_range(8)));
      end
      // writes to indexes past the register file are dropped
      if ($urandom_range(5) == 0)
         set_reg(CSR_INDEX_W'($urandom_range(int'(CSR_PLANE_WIDTH) + 1,
                                            (1 << CSR_INDEX_W) - 1)),
                 CSR_DATA_W'($urandom));
   endtask

   // sender: presents queued beats, predicts each beat the block takes
   always @(posedge clock) begin : drive
      mp2d_rsp_type predicted;
      bit           launch;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (pool_beat(req_data, predicted)) pooled_expected.push_back(predicted);
         end
         if (!start || !busy) begin
            // a drain marker holds the sender until every result is back
            if (pending_beats.size() != 0 && pending_beats[0].drain &&
                pooled_expected.size() == 0 && !rsp_valid)
               void'(pending_beats.pop_front());
            launch = pending_beats.size() != 0 && !pending_beats[0].drain &&
                     $urandom_range(99) >= gap_pct;
            start <= launch;
            if (launch) begin
               req_data <= pending_beats[0].beat;
               void'(pending_beats.pop_front());
            end
         end
      end
   end

   // result checker: each strobed beat against the oldest prediction
   always @(posedge clock) begin : watch
      mp2d_rsp_type wanted;
      if (!reset && rsp_valid) begin
         if (pooled_expected.size() == 0) begin
            report_mismatch($sformatf("result with none pending, pooled %0d",
                                      $signed(rsp_data.pooled)));
         end else begin
            wanted = pooled_expected.pop_front();
            if (rsp_data.pooled !== wanted.pooled)
               report_mismatch($sformatf("pooled %0d, predicted %0d",
                                         $signed(rsp_data.pooled), $signed(wanted.pooled)));
            if (rsp_data.last_of_plane !== wanted.last_of_plane)
               report_mismatch($sformatf("last_of_plane %b, predicted %b",
                                         rsp_data.last_of_plane, wanted.last_of_plane));
         end
      end
   end

   initial begin : stimulus
      int phase;
      // register reset values
      csr_shadow[CSR_KERNEL_HEIGHT] = 7'd2;
      csr_shadow[CSR_KERNEL_WIDTH]  = 7'd2;
      csr_shadow[CSR_STRIDE_ROWS]   = 7'd2;
      csr_shadow[CSR_STRIDE_COLS]   = 7'd2;
      csr_shadow[CSR_PAD_ROWS]      = 7'd0;
      csr_shadow[CSR_PAD_COLS]      = 7'd0;
      csr_shadow[CSR_PLANE_HEIGHT]  = 7'd64;
      csr_shadow[CSR_PLANE_WIDTH]   = 7'd64;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // kernel larger than the plane, extreme samples, dropped register indexes
      set_reg(CSR_KERNEL_HEIGHT, 7'h7F);
      set_reg(CSR_KERNEL_WIDTH, 7'd8);
      set_reg(CSR_STRIDE_ROWS, 7'd1);
      set_reg(CSR_STRIDE_COLS, 7'd1);
      set_reg(CSR_PAD_ROWS, 7'd0);
      set_reg(CSR_PAD_COLS, 7'd0);
      set_reg(CSR_PLANE_HEIGHT, 7'd2);
      set_reg(CSR_PLANE_WIDTH, 7'd3);
      set_reg(CSR_INDEX_W'(CSR_PLANE_WIDTH + 1), 7'h7F);
      set_reg('1, 7'h2A);
      queue_beat(OP_LOAD, ~MIN_SAMPLE, 1'b0);
      queue_beat(OP_LOAD, MIN_SAMPLE, 1'b0);
      queue_beat(OP_LOAD, 16'sh0000, 1'b0);
      queue_beat(OP_LOAD, 16'shFFFF, 1'b0);
      queue_beat(OP_LOAD, 16'sh5555, 1'b0);
      queue_beat(OP_LOAD, 16'shAAAA, 1'b0);
      queue_beat(OP_PRODUCE, 16'shFFFF, 1'b0);
      queue_beat(OP_LOAD, '0, 1'b1);
      queue_beat(OP_PRODUCE, 16'sh0000, 1'b0);

      // windows wholly in padding, zero kernel and masked stride and pad
      settle();
      set_reg(CSR_KERNEL_HEIGHT, 7'd0);
      set_reg(CSR_KERNEL_WIDTH, 7'd1);
      set_reg(CSR_STRIDE_ROWS, 7'h7F);
      set_reg(CSR_STRIDE_COLS, 7'd8);
      set_reg(CSR_PAD_ROWS, 7'h7F);
      set_reg(CSR_PAD_COLS, 7'd7);
      run_outputs(6);

      // largest kernel, stride and padding together
      settle();
      set_reg(CSR_KERNEL_HEIGHT, 7'd8);
      set_reg(CSR_KERNEL_WIDTH, 7'd8);
      run_outputs(4);

      // output size past the counter range on a single wide row
      settle();
      set_reg(CSR_KERNEL_HEIGHT, 7'd1);
      set_reg(CSR_KERNEL_WIDTH, 7'd1);
      set_reg(CSR_STRIDE_ROWS, 7'd1);
      set_reg(CSR_STRIDE_COLS, 7'd1);
      set_reg(CSR_PAD_ROWS, 7'd0);
      set_reg(CSR_PAD_COLS, 7'd7);
      set_reg(CSR_PLANE_HEIGHT, 7'd0);
      set_reg(CSR_PLANE_WIDTH, 7'd64);
      reload_plane();
      run_outputs(70);

      // random settings, fresh planes now and then, partial planes left behind
      phase = 0;
      while (item_total < RANDOM_ITEMS) begin
         settle();
         gap_pct = (phase % 5 == 2) ? 0 : 30;
         random_setup();
         if (!plane_written() || $urandom_range(3) == 0) reload_plane();
         run_outputs($urandom_range(1, clip(
            pooled_extent(setting(CSR_PLANE_HEIGHT), setting(CSR_PAD_ROWS),
                          setting(CSR_KERNEL_HEIGHT), setting(CSR_STRIDE_ROWS)) *
            pooled_extent(setting(CSR_PLANE_WIDTH), setting(CSR_PAD_COLS),
                          setting(CSR_KERNEL_WIDTH), setting(CSR_STRIDE_COLS)) + 2,
            1, 40)));
         phase++;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/mp2d_pkg.sv
design/max_pool_2d_plane.sv
tb/tb_max_pool_2d_plane.sv
